// File: src/ssupf_pkg.sv
// Shared types, constants and helper functions for the SPI stream packet framer.
package ssupf_pkg;

    localparam int PACKET_BYTES = 32;
    localparam int MAX_SLOTS    = 16384;

    localparam int TS_W = $clog2(MAX_SLOTS);
    localparam int PS_W = $clog2(PACKET_BYTES);
    localparam int ZC_W = $clog2(PACKET_BYTES + 1);
    localparam int CNT_W = 32;

    localparam logic [7:0] STREAM_HEADER = 8'hA8;
    localparam logic [7:0] DUMMY_BYTE    = 8'hFF;

    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_RETURN = 2'd2;

    localparam logic [1:0] KIND_DEVICE = 2'd0;
    localparam logic [1:0] KIND_HOST   = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data;
        logic       last;
    } item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_byte;
        logic       end_of_transfer;
        logic       run_last;
    } result_t;

    function automatic logic [7:0] bit_reverse(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++)
        begin
            r[i] = v[7 - i];
        end
        return r;
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

endpackage

// File: src/spi_stream_usb_packet_framer.sv
// Top level of the SPI stream packet framer: slot framing and returned-byte filtering.
// Path: an accepted item becomes a registered plan of results for the output register.
// Throughput: one item per cycle while each item yields one result and result_stall
// is low; an item that opens a transfer or a packet yields extra preamble or header
// results, one per cycle; the next item is taken as its last result is registered.
// Reset: rst_n clears all counters, the pending result plan and the output valid flag.
module spi_stream_usb_packet_framer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  ssupf_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output ssupf_pkg::result_t result
);
    import ssupf_pkg::*;

    // Framing state, updated when an item is accepted.
    logic [TS_W-1:0]  transfer_slots_reg, transfer_slots_next;
    logic [PS_W-1:0]  packet_slots_reg, packet_slots_next;
    logic [CNT_W-1:0] writes_seen_reg, writes_seen_next;
    logic             read_started_reg, read_started_next;
    logic [CNT_W-1:0] returned_index_reg, returned_index_next;

    // The plan of results still owed for the item in hand: a run of zero
    // preamble bytes, an optional stream header, then an optional final result.
    logic [ZC_W-1:0]  zero_cnt_reg, zero_cnt_next;
    logic             hdr_reg, hdr_next;
    logic             fin_valid_reg, fin_valid_next;
    result_t          fin_reg, fin_next;

    // Output register.
    logic             out_valid_reg, out_valid_next;
    result_t          out_reg, out_next;

    logic             plan_busy;
    logic             emit_en;
    logic             emit_last;
    result_t          emit_item;
    logic             accept;

    // Plan computed from the incoming item.
    logic [ZC_W-1:0]  new_zero_cnt;
    logic             new_hdr;
    logic             new_fin_valid;
    result_t          new_fin;
    logic [TS_W:0]    ts_inc;
    logic [PS_W:0]    ps_inc;
    logic             close;

    assign plan_busy = (zero_cnt_reg != '0) || hdr_reg || fin_valid_reg;
    assign emit_en   = plan_busy && (!out_valid_reg || !result_stall);

    // Pick the next owed result in order: preamble, header, final.
    always_comb
    begin
        emit_item = '0;
        emit_last = 1'b0;
        if (zero_cnt_reg != '0)
        begin
            emit_item.kind     = KIND_DEVICE;
            emit_item.out_byte = 8'h00;
            emit_last          = (zero_cnt_reg == ZC_W'(1)) && !hdr_reg && !fin_valid_reg;
        end
        else if (hdr_reg)
        begin
            emit_item.kind     = KIND_DEVICE;
            emit_item.out_byte = STREAM_HEADER;
            emit_last          = !fin_valid_reg;
        end
        else
        begin
            emit_item = fin_reg;
            emit_last = 1'b1;
        end
        emit_item.run_last = emit_last;
    end

    // A new transaction is taken once the current plan hands over its last result.
    assign item_stall = plan_busy && !(emit_en && emit_last);
    assign accept     = item_valid && !item_stall;

    // Framing of the incoming item against the current state.
    always_comb
    begin
        transfer_slots_next = transfer_slots_reg;
        packet_slots_next   = packet_slots_reg;
        writes_seen_next    = writes_seen_reg;
        read_started_next   = read_started_reg;
        returned_index_next = returned_index_reg;
        new_zero_cnt        = '0;
        new_hdr             = 1'b0;
        new_fin_valid       = 1'b0;
        new_fin             = '0;
        ts_inc              = {1'b0, transfer_slots_reg} + 1'b1;
        ps_inc              = {1'b0, packet_slots_reg} + 1'b1;
        close               = 1'b0;

        case (item.op)
            OP_WRITE, OP_READ:
            begin
                if (item.op == OP_WRITE && read_started_reg)
                begin
                    // A write after a read: report it and drop the slot.
                    new_fin_valid  = 1'b1;
                    new_fin.kind   = KIND_ERROR;
                    if (item.last)
                    begin
                        transfer_slots_next = '0;
                        packet_slots_next   = '0;
                        read_started_next   = 1'b0;
                    end
                end
                else
                begin
                    if (transfer_slots_reg == '0)
                    begin
                        new_zero_cnt = ZC_W'(PACKET_BYTES);
                    end
                    new_hdr = (packet_slots_reg == '0);
                    if (item.op == OP_WRITE)
                    begin
                        new_fin.out_byte = bit_reverse(item.data);
                        writes_seen_next = sat_inc(writes_seen_reg);
                    end
                    else
                    begin
                        new_fin.out_byte  = DUMMY_BYTE;
                        read_started_next = 1'b1;
                    end
                    if (ps_inc >= (PS_W + 1)'(PACKET_BYTES - 1))
                    begin
                        packet_slots_next = '0;
                    end
                    else
                    begin
                        packet_slots_next = ps_inc[PS_W-1:0];
                    end
                    transfer_slots_next = ts_inc[TS_W-1:0];
                    close = item.last || (ts_inc >= (TS_W + 1)'(MAX_SLOTS));
                    new_fin_valid           = 1'b1;
                    new_fin.kind            = KIND_DEVICE;
                    new_fin.end_of_transfer = close;
                    if (close)
                    begin
                        transfer_slots_next = '0;
                        packet_slots_next   = '0;
                    end
                    if (item.last)
                    begin
                        read_started_next = 1'b0;
                    end
                end
            end
            OP_RETURN:
            begin
                // Bytes that answer the write slots are discarded.
                if (returned_index_reg >= writes_seen_reg)
                begin
                    new_fin_valid    = 1'b1;
                    new_fin.kind     = KIND_HOST;
                    new_fin.out_byte = bit_reverse(item.data);
                end
                returned_index_next = sat_inc(returned_index_reg);
                if (item.last)
                begin
                    writes_seen_next    = '0;
                    returned_index_next = '0;
                end
            end
            default:
            begin
                // Unused operation: no result, no state change.
            end
        endcase
    end

    // Plan and output register next values.
    always_comb
    begin
        zero_cnt_next  = zero_cnt_reg;
        hdr_next       = hdr_reg;
        fin_valid_next = fin_valid_reg;
        fin_next       = fin_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (emit_en)
        begin
            out_valid_next = 1'b1;
            out_next       = emit_item;
            if (zero_cnt_reg != '0)
            begin
                zero_cnt_next = zero_cnt_reg - 1'b1;
            end
            else if (hdr_reg)
            begin
                hdr_next = 1'b0;
            end
            else
            begin
                fin_valid_next = 1'b0;
            end
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (accept)
        begin
            zero_cnt_next  = new_zero_cnt;
            hdr_next       = new_hdr;
            fin_valid_next = new_fin_valid;
            fin_next       = new_fin;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            transfer_slots_reg <= '0;
            packet_slots_reg   <= '0;
            writes_seen_reg    <= '0;
            read_started_reg   <= 1'b0;
            returned_index_reg <= '0;
            zero_cnt_reg       <= '0;
            hdr_reg            <= 1'b0;
            fin_valid_reg      <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                transfer_slots_reg <= transfer_slots_next;
                packet_slots_reg   <= packet_slots_next;
                writes_seen_reg    <= writes_seen_next;
                read_started_reg   <= read_started_next;
                returned_index_reg <= returned_index_next;
            end
            zero_cnt_reg  <= zero_cnt_next;
            hdr_reg       <= hdr_next;
            fin_valid_reg <= fin_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        fin_reg <= fin_next;
        out_reg <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

// File: src/ssupf_checker.sv
// Port-level assertions for the SPI stream packet framer, with their bind statement.
module ssupf_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               item_valid,
    input logic               item_stall,
    input ssupf_pkg::item_t   item,
    input logic               result_valid,
    input logic               result_stall,
    input ssupf_pkg::result_t result
);
    import ssupf_pkg::*;

    // A stalled input transaction stays offered and unchanged.
    a_item_hold: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_stall |=> item_valid && $stable(item))
        else $error("stalled item changed");

    // A stalled result transaction holds its value.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed");

    // An order error stands alone, carries no byte and closes no transfer.
    a_error_form: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.kind == KIND_ERROR
            |-> result.run_last && result.out_byte == 8'h00 && !result.end_of_transfer)
        else $error("malformed order error");

    // Read data to the host is always the single result of a returned byte.
    a_host_form: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.kind == KIND_HOST
            |-> result.run_last && !result.end_of_transfer)
        else $error("malformed host result");

    // A transfer only closes on the slot byte itself, never on preamble or header.
    a_eot_form: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.end_of_transfer
            |-> result.run_last && result.kind == KIND_DEVICE)
        else $error("end of transfer on wrong result");

endmodule

bind spi_stream_usb_packet_framer ssupf_checker u_ssupf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

// File: dv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the SPI stream packet framer, with its own framing predictor.
module tb;
    import ssupf_pkg::*;

    localparam int CLK_HALF        = 4;
    localparam int RESET_CYCLES    = 7;
    // Even with the receiver stalling 86% of the time, a quiet stretch of this length
    // is far beyond anything a working block produces.
    localparam int STUCK_LIMIT     = 2000;
    localparam int SETTLE_CYCLES   = 20;
    localparam int MISMATCH_PRINTS = 20;
    localparam int MIX_ITEMS       = 28;

    // The package names three operations; the fourth encoding is simply ignored by the block.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    item_valid = 1'b0;
    logic    item_stall;
    item_t   item = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    // Items waiting to be driven, and the framed output that accepted items must produce.
    item_t   command_stream_q[$];
    result_t framed_output_q[$];
    result_t oldest_output;

    // Predictor state, cleared as the block's reset clears it.
    int          slots_in_transfer = 0;
    int          slots_in_packet = 0;
    logic [31:0] write_count = '0;
    logic        reading = 1'b0;
    logic [31:0] return_count = '0;

    // Set when the driver puts an item on the bus, cleared when the block takes it.
    bit item_busy = 1'b0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    int stuck_cycles = 0;
    int mismatch_count = 0;
    int items_taken = 0;
    int results_checked = 0;
    int transfers_closed = 0;
    int order_errors = 0;
    int host_bytes = 0;

    spi_stream_usb_packet_framer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    function automatic logic [7:0] mirror_byte(input logic [7:0] v);
        logic [7:0] m;
        for (int i = 0; i < 8; i++)
        begin
            m[i] = v[7 - i];
        end
        return m;
    endfunction

    // Works out everything one accepted item makes the framer emit, and appends it to the
    // store of framed output. The final entry of each burst carries run_last.
    function automatic void frame_item(input item_t it);
        result_t    burst[$];
        result_t    r;
        logic [7:0] slot_byte;
        logic       close;
        r = '0;
        r.kind = KIND_DEVICE;
        if (it.op == OP_WRITE || it.op == OP_READ)
        begin
            if (it.op == OP_WRITE && reading)
            begin
                // A write once reading has begun is flagged and dropped. With last set it
                // still closes the slot phase, but no end-of-transfer marker goes out.
                r.kind = KIND_ERROR;
                burst.push_back(r);
                if (it.last)
                begin
                    slots_in_transfer = 0;
                    slots_in_packet = 0;
                    reading = 1'b0;
                end
            end
            else
            begin
                // A fresh transfer opens with a whole packet of zero bytes.
                if (slots_in_transfer == 0)
                begin
                    repeat (PACKET_BYTES) burst.push_back(r);
                end
                if (slots_in_packet == 0)
                begin
                    r.out_byte = STREAM_HEADER;
                    burst.push_back(r);
                end
                if (it.op == OP_WRITE)
                begin
                    slot_byte = mirror_byte(it.data);
                    if (write_count != '1)
                    begin
                        write_count = write_count + 1;
                    end
                end
                else
                begin
                    slot_byte = DUMMY_BYTE;
                    reading = 1'b1;
                end
                slots_in_packet++;
                if (slots_in_packet >= PACKET_BYTES - 1)
                begin
                    slots_in_packet = 0;
                end
                slots_in_transfer++;
                // The transfer ends with the command or when it reaches the slot limit.
                close = it.last || (slots_in_transfer >= MAX_SLOTS);
                r.out_byte = slot_byte;
                r.end_of_transfer = close;
                burst.push_back(r);
                if (close)
                begin
                    slots_in_transfer = 0;
                    slots_in_packet = 0;
                end
                if (it.last)
                begin
                    reading = 1'b0;
                end
            end
        end
        else if (it.op == OP_RETURN)
        begin
            // Bytes clocked in while the command's writes went out carry nothing useful.
            if (return_count >= write_count)
            begin
                r.kind = KIND_HOST;
                r.out_byte = mirror_byte(it.data);
                burst.push_back(r);
            end
            if (return_count != '1)
            begin
                return_count = return_count + 1;
            end
            if (it.last)
            begin
                write_count = '0;
                return_count = '0;
            end
        end
        if (burst.size() > 0)
        begin
            burst[burst.size() - 1].run_last = 1'b1;
        end
        foreach (burst[i])
        begin
            framed_output_q.push_back(burst[i]);
        end
    endfunction

    task automatic queue_item(input logic [1:0] op, input logic [7:0] data, input logic last);
        item_t it;
        it.op = op;
        it.data = data;
        it.last = last;
        command_stream_q.push_back(it);
    endtask

    // One SPI command: writes then reads, followed by the bytes the device hands back.
    task automatic queue_command(input int writes, input int reads, input int returns);
        for (int i = 0; i < writes + reads; i++)
        begin
            queue_item((i < writes) ? OP_WRITE : OP_READ, 8'($urandom_range(255)),
                       i == writes + reads - 1);
        end
        for (int i = 0; i < returns; i++)
        begin
            queue_item(OP_RETURN, 8'($urandom_range(255)), i == returns - 1);
        end
    endtask

    // Mostly well-formed commands with random content; the rest is noise, writes slipped
    // in after reads, and commands whose returned bytes are cut short or missing.
    task automatic queue_random_mix(input int target);
        int start;
        int writes;
        int reads;
        start = command_stream_q.size();
        while (command_stream_q.size() - start < target)
        begin
            writes = $urandom_range(6);
            reads = $urandom_range(8);
            if ($urandom_range(7) == 0)
            begin
                // Between 26 and 38 slots; at 32 or more a second stream header is needed in the transfer.
                writes = $urandom_range(4);
                reads = $urandom_range(34, 26);
            end
            if (writes + reads == 0)
            begin
                reads = 1;
            end
            case ($urandom_range(9))
                0:
                begin
                    queue_item(2'($urandom_range(3)), 8'($urandom_range(255)),
                               $urandom_range(3) == 0);
                end
                1:
                begin
                    queue_item(OP_READ, 8'($urandom_range(255)), 1'b0);
                    queue_item(OP_WRITE, 8'($urandom_range(255)), 1'($urandom_range(1)));
                end
                2:
                begin
                    queue_command(writes, reads, $urandom_range(writes + reads));
                end
                default:
                begin
                    queue_command(writes, reads, writes + reads);
                end
            endcase
        end
    endtask

    // Holds the stimulus back until every item has gone in and all its output has come out.
    task automatic wait_for_drain();
        while (command_stream_q.size() != 0 || item_busy || framed_output_q.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // Driver: inputs move on the falling edge only. An item stays on the bus, unchanged,
    // until the block takes it; only then may the valid drop while the driver idles.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!item_busy && command_stream_q.size() != 0 &&
                $urandom_range(99) >= send_idle_pct)
            begin
                item <= command_stream_q.pop_front();
                item_valid <= 1'b1;
                item_busy = 1'b1;
            end
            else if (!item_busy)
            begin
                item_valid <= 1'b0;
            end
            result_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Monitor: both channels are sampled on the rising edge. An output transaction is
    // checked against the oldest framed entry before any newly accepted item is predicted.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            stuck_cycles++;
            if (result_valid && !result_stall)
            begin
                stuck_cycles = 0;
                results_checked++;
                if (framed_output_q.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MISMATCH_PRINTS)
                    begin
                        $display("%0t: output with none pending: expected nothing,",
                                 $time);
                        $display("%0t: got kind=%0d byte=%02h eot=%0b run_last=%0b",
                                 $time, result.kind, result.out_byte,
                                 result.end_of_transfer, result.run_last);
                    end
                end
                else
                begin
                    oldest_output = framed_output_q.pop_front();
                    if (result.kind !== oldest_output.kind ||
                        result.out_byte !== oldest_output.out_byte ||
                        result.end_of_transfer !== oldest_output.end_of_transfer ||
                        result.run_last !== oldest_output.run_last)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MISMATCH_PRINTS)
                        begin
                            $display("%0t: expected kind=%0d byte=%02h eot=%0b run_last=%0b",
                                     $time, oldest_output.kind, oldest_output.out_byte,
                                     oldest_output.end_of_transfer, oldest_output.run_last);
                            $display("%0t: actual   kind=%0d byte=%02h eot=%0b run_last=%0b",
                                     $time, result.kind, result.out_byte,
                                     result.end_of_transfer, result.run_last);
                        end
                    end
                    if (oldest_output.end_of_transfer)
                    begin
                        transfers_closed++;
                    end
                    if (oldest_output.kind == KIND_ERROR)
                    begin
                        order_errors++;
                    end
                    if (oldest_output.kind == KIND_HOST)
                    begin
                        host_bytes++;
                    end
                end
            end
            if (item_valid && !item_stall)
            begin
                stuck_cycles = 0;
                items_taken++;
                frame_item(item);
                item_busy = 1'b0;
            end
        end
    end

    // Watchdog: the run is abandoned if neither channel completes a transaction for too long.
    initial
    begin
        while (stuck_cycles < STUCK_LIMIT)
        begin
            @(negedge clk);
        end
        $display("%0t: timed out, no transaction for %0d cycles", $time, STUCK_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // First regime: the sender rarely idles and the receiver stalls most of the time.
        send_idle_pct = 14;
        recv_stall_pct = 86;

        // Opening command: extreme write bytes, then reads. The first slot brings the zero
        // preamble and the stream header; the last read closes the transfer.
        queue_item(OP_WRITE, 8'h00, 1'b0);
        queue_item(OP_WRITE, 8'hFF, 1'b0);
        queue_item(OP_WRITE, 8'h01, 1'b0);
        queue_item(OP_READ, 8'h00, 1'b0);
        queue_item(OP_READ, 8'hFF, 1'b1);
        // Returned bytes: the first three positions sit under the write count and vanish.
        queue_item(OP_RETURN, 8'h12, 1'b0);
        queue_item(OP_RETURN, 8'hFF, 1'b0);
        queue_item(OP_RETURN, 8'h80, 1'b0);
        queue_item(OP_RETURN, 8'h01, 1'b0);
        queue_item(OP_RETURN, 8'h00, 1'b1);
        // Writes after a read are flagged; the second also ends the slot phase unmarked.
        queue_item(OP_READ, 8'h3C, 1'b0);
        queue_item(OP_WRITE, 8'h5A, 1'b0);
        queue_item(OP_WRITE, 8'hA5, 1'b1);
        // So the next slot opens a fresh transfer, and its write count is honoured.
        queue_item(OP_WRITE, 8'hC3, 1'b1);
        queue_item(OP_RETURN, 8'h7E, 1'b0);
        queue_item(OP_RETURN, 8'h81, 1'b1);
        // The unused operation leaves no trace, whatever last says.
        queue_item(OP_UNUSED, 8'hFF, 1'b1);
        queue_item(OP_UNUSED, 8'h00, 1'b0);
        // A returned byte with no command behind it is delivered at once.
        queue_item(OP_RETURN, 8'hF0, 1'b1);
        queue_random_mix(MIX_ITEMS);
        wait_for_drain();

        // Second regime: the sender idles most of the time and the receiver seldom stalls.
        send_idle_pct = 86;
        recv_stall_pct = 14;
        queue_random_mix(MIX_ITEMS);
        wait_for_drain();

        // Third regime, flat out on both channels.
        send_idle_pct = 0;
        recv_stall_pct = 0;
        queue_random_mix(MIX_ITEMS);
        wait_for_drain();

        // Anything the block emits from here on has no item behind it and is caught above.
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        if (framed_output_q.size() != 0)
        begin
            $display("%0t: %0d framed outputs never arrived", $time, framed_output_q.size());
        end

        $display("Run covered %0d input transactions and %0d checked outputs over %0d transfers,",
                 items_taken, results_checked, transfers_closed);
        $display("under three stall regimes; %0d order errors, %0d bytes to the host.",
                 order_errors, host_bytes);
        if (mismatch_count == 0 && framed_output_q.size() == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
